// ===== rtl/plane_contact_velocity_bounce_assert.svh =====
// Assertion macros used by the plane contact bounce top level.
`ifndef PLANE_CONTACT_VELOCITY_BOUNCE_ASSERT_SVH
`define PLANE_CONTACT_VELOCITY_BOUNCE_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define PCVB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define PCVB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcvb_pkg.sv =====
// Types, constants and step functions for the plane contact bounce pipeline.
`default_nettype none
package pcvb_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 33;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] surface_distance;
    } pcvb_in_t;

    typedef struct packed {
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic               bounced;
    } pcvb_out_t;

    // Fields that ride along with a word through the root and divide stages
    typedef struct packed {
        logic             bounce;
        logic [2:0][31:0] vel;
        logic [2:0]       neg;
        logic [2:0][30:0] mag_a;
    } pcvb_carry_t;

    typedef struct packed {
        pcvb_carry_t carry;
        logic [63:0] sum_v;
        logic [63:0] sum_a;
    } pcvb_front_t;

    typedef struct packed {
        pcvb_carry_t carry;
        logic [31:0] speed;
        logic [31:0] nw;
    } pcvb_root_t;

    typedef struct packed {
        pcvb_carry_t      carry;
        logic             nw_zero;
        logic [2:0][32:0] quo;
    } pcvb_quo_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sq_step_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] quo;
        logic [63:0] num;
    } div_step_t;

    // One digit of a floor square root: take two radicand bits
    function automatic sq_step_t sq_step(sq_step_t cur, logic [1:0] pair);
        logic [35:0] acc;
        logic [35:0] trial;
        sq_step_t    nxt;
        acc   = {cur.rem, pair};
        trial = {2'b00, cur.root, 2'b01};
        if (acc >= trial)
        begin
            nxt.rem  = 34'(acc - trial);
            nxt.root = {cur.root[30:0], 1'b1};
        end
        else
        begin
            nxt.rem  = acc[33:0];
            nxt.root = {cur.root[30:0], 1'b0};
        end
        return nxt;
    endfunction

    // One quotient bit of a restoring divide
    function automatic div_step_t div_step(div_step_t cur, logic [31:0] den);
        logic [32:0] acc;
        div_step_t   nxt;
        acc     = {cur.rem, cur.num[63]};
        nxt.num = {cur.num[62:0], 1'b0};
        if (acc >= {1'b0, den})
        begin
            nxt.rem = 32'(acc - {1'b0, den});
            nxt.quo = {cur.quo[31:0], 1'b1};
        end
        else
        begin
            nxt.rem = acc[31:0];
            nxt.quo = {cur.quo[31:0], 1'b0};
        end
        return nxt;
    endfunction

    // Apply sign and clamp to 32-bit signed range
    function automatic logic [31:0] sat32(logic neg, logic [32:0] q);
        logic [31:0] res;
        if (neg)
        begin
            if (q >= 33'h080000000)
                res = 32'h80000000;
            else
                res = 32'(33'd0 - q);
        end
        else
        begin
            if (q > 33'h07FFFFFFF)
                res = 32'h7FFFFFFF;
            else
                res = q[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/plane_contact_velocity_bounce.sv =====
// Top level of the plane contact velocity bounce pipeline.
// Takes one contact word per cycle while contact_stall is low and returns one
// velocity word per contact, in order, through 8 front stages (dot product,
// reflection, magnitude shift, sums of squares), 32 square-root stages, 2
// multiply and round stages, 33 divide stages and the output register. All
// stages move together; while the output word is held by bounce_stall the
// whole pipeline holds and contact_stall is raised.
`default_nettype none
module plane_contact_velocity_bounce (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                contact_valid,
    output logic                contact_stall,
    input  pcvb_pkg::pcvb_in_t  contact,
    output logic                bounce_valid,
    input  logic                bounce_stall,
    output pcvb_pkg::pcvb_out_t bounce
);
    import pcvb_pkg::*;

`include "plane_contact_velocity_bounce_assert.svh"

    logic        adv;
    logic        front_valid;
    pcvb_front_t front_data;
    logic        root_valid;
    pcvb_root_t  root_data;
    logic        quo_valid;
    pcvb_quo_t   quo_data;
    pcvb_out_t   out_next;
    logic        bounce_valid_reg;
    pcvb_out_t   bounce_reg;

    // Move the pipeline unless the output word is held
    assign adv           = !bounce_valid_reg || !bounce_stall;
    assign contact_stall = !adv;

    pcvb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (contact_valid),
        .in_data   (contact),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    pcvb_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_data  (root_data)
    );

    pcvb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (root_valid),
        .in_data   (root_data),
        .out_valid (quo_valid),
        .out_data  (quo_data)
    );

    // Select pass-through, zero or signed saturated quotient
    always_comb
    begin
        if (!quo_data.carry.bounce)
        begin
            out_next.out_vel_x = quo_data.carry.vel[0];
            out_next.out_vel_y = quo_data.carry.vel[1];
            out_next.out_vel_z = quo_data.carry.vel[2];
            out_next.bounced   = 1'b0;
        end
        else if (quo_data.nw_zero)
        begin
            out_next.out_vel_x = '0;
            out_next.out_vel_y = '0;
            out_next.out_vel_z = '0;
            out_next.bounced   = 1'b1;
        end
        else
        begin
            out_next.out_vel_x = sat32(quo_data.carry.neg[0], quo_data.quo[0]);
            out_next.out_vel_y = sat32(quo_data.carry.neg[1], quo_data.quo[1]);
            out_next.out_vel_z = sat32(quo_data.carry.neg[2], quo_data.quo[2]);
            out_next.bounced   = 1'b1;
        end
    end

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bounce_valid_reg <= 1'b0;
        else if (adv)
            bounce_valid_reg <= quo_valid;
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (adv)
            bounce_reg <= out_next;
    end

    assign bounce_valid = bounce_valid_reg;
    assign bounce       = bounce_reg;

    `PCVB_ASSERT_NEXT(a_freeze, contact_stall, $stable(root_valid) && $stable(quo_valid),
        "pipeline moved while held")
    `PCVB_ASSERT_NOW(a_pass, quo_valid && !quo_data.carry.bounce,
        out_next.out_vel_x == quo_data.carry.vel[0] && !out_next.bounced,
        "pass-through word altered")
    `PCVB_ASSERT_NOW(a_sign, quo_valid && quo_data.carry.bounce && !quo_data.carry.neg[0],
        !out_next.out_vel_x[31], "positive component came out negative")

endmodule
`default_nettype wire

// ===== rtl/pcvb_front.sv =====
// Front pipeline: dot product, reflection, rescale shift and sums of squares.
`default_nettype none
module pcvb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  pcvb_pkg::pcvb_in_t    in_data,
    output logic                  out_valid,
    output pcvb_pkg::pcvb_front_t out_data
);
    import pcvb_pkg::*;

    localparam int STAGES = 8;

    logic [STAGES-1:0] valid_reg;

    logic [2:0][31:0] vel_in;
    logic [2:0][15:0] nrm_in;

    // stage 1
    logic [2:0][47:0] prod1_next;
    logic [2:0][63:0] sq1_next;
    logic             dpos1_next;
    logic [2:0][31:0] vel1_reg;
    logic [2:0][15:0] nrm1_reg;
    logic [2:0][47:0] prod1_reg;
    logic [2:0][63:0] sq1_reg;
    logic             dpos1_reg;

    // stage 2
    logic signed [49:0] var30;
    logic signed [49:0] var_rnd;
    logic               bounce2_next;
    logic [63:0]        sumv2_next;
    logic [2:0][31:0]   vel2_reg;
    logic [2:0][15:0]   nrm2_reg;
    logic [35:0]        var2_reg;
    logic               bounce2_reg;
    logic [63:0]        sumv2_reg;

    // stage 3
    logic [2:0][52:0] r3_next;
    logic [2:0][31:0] vel3_reg;
    logic [2:0][52:0] r3_reg;
    logic             bounce3_reg;
    logic [63:0]      sumv3_reg;

    // stage 4
    logic [2:0]       neg4_next;
    logic [2:0][39:0] mag4_next;
    logic [2:0][31:0] vel4_reg;
    logic [2:0]       neg4_reg;
    logic [2:0][39:0] mag4_reg;
    logic             bounce4_reg;
    logic [63:0]      sumv4_reg;

    // stage 5
    logic [39:0]      max5_next;
    logic [2:0][31:0] vel5_reg;
    logic [2:0]       neg5_reg;
    logic [2:0][39:0] mag5_reg;
    logic [39:0]      max5_reg;
    logic             bounce5_reg;
    logic [63:0]      sumv5_reg;

    // stage 6
    logic [3:0]       shift6;
    logic [2:0][30:0] a6_next;
    logic [2:0][31:0] vel6_reg;
    logic [2:0]       neg6_reg;
    logic [2:0][30:0] a6_reg;
    logic             bounce6_reg;
    logic [63:0]      sumv6_reg;

    // stage 7
    logic [2:0][63:0] asq7_next;
    logic [2:0][31:0] vel7_reg;
    logic [2:0]       neg7_reg;
    logic [2:0][30:0] a7_reg;
    logic [2:0][63:0] asq7_reg;
    logic             bounce7_reg;
    logic [63:0]      sumv7_reg;

    // stage 8
    pcvb_front_t out_next;
    pcvb_front_t out_reg;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    // Stage 1: products with the normal and squares of the velocity components
    always_comb
    begin
        vel_in[0] = in_data.vel_x;
        vel_in[1] = in_data.vel_y;
        vel_in[2] = in_data.vel_z;
        nrm_in[0] = in_data.normal_x;
        nrm_in[1] = in_data.normal_y;
        nrm_in[2] = in_data.normal_z;
        for (int i = 0; i < 3; i++)
        begin
            logic [31:0] mv;
            mv = vel_in[i][31] ? (32'd0 - vel_in[i]) : vel_in[i];
            prod1_next[i] = 48'($signed({{16{vel_in[i][31]}}, vel_in[i]})
                              * $signed({{32{nrm_in[i][15]}}, nrm_in[i]}));
            sq1_next[i]   = {32'd0, mv} * {32'd0, mv};
        end
        dpos1_next = !in_data.surface_distance[31] && (in_data.surface_distance != '0);
    end

    // Stage 2: signed dot product, bounce test, scaled projection, sum of velocity squares
    always_comb
    begin
        var30 = $signed({{2{prod1_reg[2][47]}}, prod1_reg[2]})
              - $signed({{2{prod1_reg[0][47]}}, prod1_reg[0]})
              - $signed({{2{prod1_reg[1][47]}}, prod1_reg[1]});
        var_rnd      = var30 + 50'sd8192;
        bounce2_next = dpos1_reg ? (!var30[49] && (var30 != '0)) : var30[49];
        sumv2_next   = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
    end

    // Stage 3: twice the projection times each normal component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [51:0] pr;
            pr = 52'($signed({{16{var2_reg[35]}}, var2_reg})
                   * $signed({{36{nrm2_reg[i][15]}}, nrm2_reg[i]}));
            r3_next[i] = {pr, 1'b0};
        end
    end

    // Stage 4: reflected vector, split into sign and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [52:0] rt;
            logic [38:0] rr;
            logic [39:0] vx;
            logic [39:0] w;
            rt = 53'($signed(r3_reg[i]) + 53'sd8192);
            rr = rt[52:14];
            vx = {{8{vel3_reg[i][31]}}, vel3_reg[i]};
            if (i == 2)
                w = vx - {rr[38], rr};
            else
                w = vx + {rr[38], rr};
            neg4_next[i] = w[39];
            mag4_next[i] = w[39] ? (40'd0 - w) : w;
        end
    end

    // Stage 5: largest magnitude
    always_comb
    begin
        max5_next = mag4_reg[0];
        if (mag4_reg[1] > max5_next)
            max5_next = mag4_reg[1];
        if (mag4_reg[2] > max5_next)
            max5_next = mag4_reg[2];
    end

    // Stage 6: shift magnitudes below 2^31
    always_comb
    begin
        shift6 = '0;
        for (int k = 31; k < 40; k++)
        begin
            if (max5_reg[k])
                shift6 = 4'(k - 30);
        end
        for (int i = 0; i < 3; i++)
            a6_next[i] = 31'(mag5_reg[i] >> shift6);
    end

    // Stage 7: squares of the shifted magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            asq7_next[i] = {33'd0, a6_reg[i]} * {33'd0, a6_reg[i]};
    end

    // Stage 8: sum and pack
    always_comb
    begin
        out_next.carry.bounce = bounce7_reg;
        out_next.carry.vel    = vel7_reg;
        out_next.carry.neg    = neg7_reg;
        out_next.carry.mag_a  = a7_reg;
        out_next.sum_v        = sumv7_reg;
        out_next.sum_a        = asq7_reg[0] + asq7_reg[1] + asq7_reg[2];
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vel1_reg    <= vel_in;
            nrm1_reg    <= nrm_in;
            prod1_reg   <= prod1_next;
            sq1_reg     <= sq1_next;
            dpos1_reg   <= dpos1_next;

            vel2_reg    <= vel1_reg;
            nrm2_reg    <= nrm1_reg;
            var2_reg    <= var_rnd[49:14];
            bounce2_reg <= bounce2_next;
            sumv2_reg   <= sumv2_next;

            vel3_reg    <= vel2_reg;
            r3_reg      <= r3_next;
            bounce3_reg <= bounce2_reg;
            sumv3_reg   <= sumv2_reg;

            vel4_reg    <= vel3_reg;
            neg4_reg    <= neg4_next;
            mag4_reg    <= mag4_next;
            bounce4_reg <= bounce3_reg;
            sumv4_reg   <= sumv3_reg;

            vel5_reg    <= vel4_reg;
            neg5_reg    <= neg4_reg;
            mag5_reg    <= mag4_reg;
            max5_reg    <= max5_next;
            bounce5_reg <= bounce4_reg;
            sumv5_reg   <= sumv4_reg;

            vel6_reg    <= vel5_reg;
            neg6_reg    <= neg5_reg;
            a6_reg      <= a6_next;
            bounce6_reg <= bounce5_reg;
            sumv6_reg   <= sumv5_reg;

            vel7_reg    <= vel6_reg;
            neg7_reg    <= neg6_reg;
            a7_reg      <= a6_reg;
            asq7_reg    <= asq7_next;
            bounce7_reg <= bounce6_reg;
            sumv7_reg   <= sumv6_reg;

            out_reg     <= out_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/pcvb_isqrt.sv =====
// Pipelined floor square roots of both sums of squares, one digit per stage.
`default_nettype none
module pcvb_isqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  pcvb_pkg::pcvb_front_t in_data,
    output logic                  out_valid,
    output pcvb_pkg::pcvb_root_t  out_data
);
    import pcvb_pkg::*;

    typedef struct packed {
        pcvb_carry_t carry;
        logic [63:0] xv;
        logic [63:0] xa;
        sq_step_t    sv;
        sq_step_t    sa;
    } stage_t;

    logic [SQ_STEPS-1:0] valid_reg;
    stage_t              pipe_reg  [SQ_STEPS];
    stage_t              pipe_next [SQ_STEPS];

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[SQ_STEPS-2:0], in_valid};
    end

    // One radicand bit pair per stage for each root
    always_comb
    begin
        stage_t src;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                src.carry = in_data.carry;
                src.xv    = in_data.sum_v;
                src.xa    = in_data.sum_a;
                src.sv    = '0;
                src.sa    = '0;
            end
            else
            begin
                src = pipe_reg[k-1];
            end
            pipe_next[k].carry = src.carry;
            pipe_next[k].sv    = sq_step(src.sv, src.xv[63:62]);
            pipe_next[k].sa    = sq_step(src.sa, src.xa[63:62]);
            pipe_next[k].xv    = {src.xv[61:0], 2'b00};
            pipe_next[k].xa    = {src.xa[61:0], 2'b00};
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    assign out_valid      = valid_reg[SQ_STEPS-1];
    assign out_data.carry = pipe_reg[SQ_STEPS-1].carry;
    assign out_data.speed = pipe_reg[SQ_STEPS-1].sv.root;
    assign out_data.nw    = pipe_reg[SQ_STEPS-1].sa.root;

endmodule
`default_nettype wire

// ===== rtl/pcvb_div.sv =====
// Rescale to the original speed: multiply, round, then a bit-per-stage divide.
`default_nettype none
module pcvb_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  pcvb_pkg::pcvb_root_t in_data,
    output logic                 out_valid,
    output pcvb_pkg::pcvb_quo_t  out_data
);
    import pcvb_pkg::*;

    typedef struct packed {
        pcvb_carry_t     carry;
        logic [31:0]     nw;
        div_step_t [2:0] dv;
    } stage_t;

    logic [1:0]           pre_valid_reg;
    logic [DIV_STEPS-1:0] valid_reg;

    // multiply stage
    logic [2:0][63:0] prod_next;
    pcvb_carry_t      carry1_reg;
    logic [31:0]      nw1_reg;
    logic [2:0][63:0] prod1_reg;

    // rounding stage
    pcvb_carry_t      carry2_reg;
    logic [31:0]      nw2_reg;
    logic [2:0][63:0] num2_reg;

    stage_t pipe_reg  [DIV_STEPS];
    stage_t pipe_next [DIV_STEPS];

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= '0;
            valid_reg     <= '0;
        end
        else if (adv)
        begin
            pre_valid_reg <= {pre_valid_reg[0], in_valid};
            valid_reg     <= {valid_reg[DIV_STEPS-2:0], pre_valid_reg[1]};
        end
    end

    // Magnitude times speed
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod_next[i] = {33'd0, in_data.carry.mag_a[i]} * {32'd0, in_data.speed};
    end

    // One quotient bit per stage; the quotient never reaches 2^33
    always_comb
    begin
        stage_t src;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                src.carry = carry2_reg;
                src.nw    = nw2_reg;
                for (int i = 0; i < 3; i++)
                begin
                    src.dv[i].rem = {1'b0, num2_reg[i][63:33]};
                    src.dv[i].num = {num2_reg[i][32:0], 31'd0};
                    src.dv[i].quo = '0;
                end
            end
            else
            begin
                src = pipe_reg[k-1];
            end
            pipe_next[k].carry = src.carry;
            pipe_next[k].nw    = src.nw;
            for (int i = 0; i < 3; i++)
                pipe_next[k].dv[i] = div_step(src.dv[i], src.nw);
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry1_reg <= in_data.carry;
            nw1_reg    <= in_data.nw;
            prod1_reg  <= prod_next;
            carry2_reg <= carry1_reg;
            nw2_reg    <= nw1_reg;
            for (int i = 0; i < 3; i++)
                num2_reg[i] <= prod1_reg[i] + {33'd0, nw1_reg[31:1]};
            for (int k = 0; k < DIV_STEPS; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    always_comb
    begin
        out_data.carry   = pipe_reg[DIV_STEPS-1].carry;
        out_data.nw_zero = (pipe_reg[DIV_STEPS-1].nw == '0);
        for (int i = 0; i < 3; i++)
            out_data.quo[i] = pipe_reg[DIV_STEPS-1].dv[i].quo;
    end

    assign out_valid = valid_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== dv/plane_contact_velocity_bounce_test.sv =====
// Self-checking testbench for the plane contact velocity bounce pipeline.
`timescale 1ns / 1ps
module plane_contact_velocity_bounce_test;
    import pcvb_pkg::*;

    localparam int RANDOM_WORDS = 1430;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 120;

    logic      clk;
    logic      rst_n;
    logic      contact_valid;
    logic      contact_stall;
    pcvb_in_t  contact;
    logic      bounce_valid;
    logic      bounce_stall;
    pcvb_out_t bounce;

    int sent_words;
    int idle_cycles;

    plane_contact_velocity_bounce dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .contact_valid (contact_valid),
        .contact_stall (contact_stall),
        .contact       (contact),
        .bounce_valid  (bounce_valid),
        .bounce_stall  (bounce_stall),
        .bounce        (bounce)
    );

    // Round x / 2^14 to nearest, ties toward +infinity
    function automatic longint round14(longint x);
        return (x + 64'sd8192) >>> 14;
    endfunction

    function automatic longint unsigned abs_u(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(bit neg, longint unsigned q);
        if (neg)
            return (q >= 64'h80000000) ? 32'h80000000 : 32'(-q);
        return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    endfunction

    // Reflect the velocity about the contact plane and restore its speed
    function automatic pcvb_out_t reflect_velocity(pcvb_in_t c);
        longint          v[3];
        longint          n[3];
        longint          w[3];
        longint          dot30;
        longint          dot16;
        longint unsigned a[3];
        longint unsigned acc;
        longint unsigned speed;
        longint unsigned nw;
        longint unsigned mx;
        int              s;
        bit              hit;
        logic [31:0]     res[3];
        v[0] = c.vel_x;
        v[1] = c.vel_y;
        v[2] = c.vel_z;
        n[0] = c.normal_x;
        n[1] = c.normal_y;
        n[2] = c.normal_z;
        dot30 = -(v[0] * n[0]) - (v[1] * n[1]) + v[2] * n[2];
        hit = (c.surface_distance > 0) ? (dot30 > 0) : (dot30 < 0);
        if (!hit)
            return {c.vel_x, c.vel_y, c.vel_z, 1'b0};
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += abs_u(v[i]) * abs_u(v[i]);
        speed = floor_root(acc);
        dot16 = round14(dot30);
        w[0] = v[0] + round14(2 * dot16 * n[0]);
        w[1] = v[1] + round14(2 * dot16 * n[1]);
        w[2] = v[2] - round14(2 * dot16 * n[2]);
        mx = 0;
        for (int i = 0; i < 3; i++)
            if (abs_u(w[i]) > mx)
                mx = abs_u(w[i]);
        s = 0;
        while ((mx >> s) >= 64'h80000000)
            s++;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = abs_u(w[i]) >> s;
            acc += a[i] * a[i];
        end
        nw = floor_root(acc);
        for (int i = 0; i < 3; i++)
            res[i] = (nw == 0) ? 32'd0 : clamp32(w[i] < 0, (a[i] * speed + nw / 2) / nw);
        return {res[0], res[1], res[2], 1'b1};
    endfunction

    // In-order store of predicted velocity words
    class bounce_scoreboard;
        pcvb_out_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task note_contact(pcvb_in_t c);
            pending.push_back(reflect_velocity(c));
        endtask

        task check_bounce(pcvb_out_t got);
            pcvb_out_t exp;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            exp = pending.pop_front();
            if (got.out_vel_x !== exp.out_vel_x)
                report($sformatf("out_vel_x %h expected %h", got.out_vel_x, exp.out_vel_x));
            if (got.out_vel_y !== exp.out_vel_y)
                report($sformatf("out_vel_y %h expected %h", got.out_vel_y, exp.out_vel_y));
            if (got.out_vel_z !== exp.out_vel_z)
                report($sformatf("out_vel_z %h expected %h", got.out_vel_z, exp.out_vel_z));
            if (got.bounced !== exp.bounced)
                report($sformatf("bounced %b expected %b", got.bounced, exp.bounced));
        endtask
    endclass

    bounce_scoreboard sb = new();

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one contact word and hold it until accepted
    task automatic send_contact(pcvb_in_t c, int gap);
        if (gap > 0)
        begin
            contact_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        contact       <= c;
        contact_valid <= 1'b1;
        do
            @(posedge clk);
        while (contact_stall);
        sb.note_contact(c);
        sent_words++;
    endtask

    function automatic pcvb_in_t make_contact(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                              int nx, int ny, int nz, logic [31:0] d);
        pcvb_in_t c;
        c.vel_x            = vx;
        c.vel_y            = vy;
        c.vel_z            = vz;
        c.normal_x         = 16'(nx);
        c.normal_y         = 16'(ny);
        c.normal_z         = 16'(nz);
        c.surface_distance = d;
        return c;
    endfunction

    function automatic int rand_normal();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // Random contact: mostly unit normals with moderate speeds, some full range
    function automatic pcvb_in_t random_contact();
        pcvb_in_t c;
        int       mode;
        int       nx;
        int       ny;
        int       nz;
        mode = $urandom_range(0, 9);
        c = make_contact($urandom, $urandom, $urandom, rand_normal(), rand_normal(),
                         rand_normal(), $urandom);
        if (mode < 6)
        begin
            // roughly unit normal along one axis with a tilt
            nx = int'($urandom_range(0, 9000)) - 4500;
            ny = int'($urandom_range(0, 9000)) - 4500;
            nz = ($urandom_range(0, 1) != 0) ? 15000 : -15000;
            case ($urandom_range(0, 2))
                0: c = make_contact(c.vel_x, c.vel_y, c.vel_z, nz, nx, ny, c.surface_distance);
                1: c = make_contact(c.vel_x, c.vel_y, c.vel_z, nx, nz, ny, c.surface_distance);
                default: c = make_contact(c.vel_x, c.vel_y, c.vel_z, nx, ny, nz,
                                          c.surface_distance);
            endcase
            c.vel_x = $signed(c.vel_x) >>> $urandom_range(0, 16);
            c.vel_y = $signed(c.vel_y) >>> $urandom_range(0, 16);
            c.vel_z = $signed(c.vel_z) >>> $urandom_range(0, 16);
        end
        if (mode == 9)
            c.surface_distance = $urandom_range(0, 2) - 1;
        return c;
    endfunction

    // Stimulus
    initial
    begin
        pcvb_in_t dir[$];
        contact_valid = 1'b0;
        contact       = '0;
        sent_words    = 0;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back(make_contact(32'h00010000, 0, 0, -16384, 0, 0, 1));
        dir.push_back(make_contact(32'h00010000, 0, 0, -16384, 0, 0, 0));
        dir.push_back(make_contact(32'hFFFF0000, 0, 0, -16384, 0, 0, -1));
        dir.push_back(make_contact(0, 0, 32'h00020000, 0, 0, 16384, 32'h7FFFFFFF));
        dir.push_back(make_contact(0, 0, 32'h00020000, 0, 0, 16384, 32'h80000000));
        // zero dot product never reflects
        dir.push_back(make_contact(32'h00010000, 32'h00010000, 0, 16384, -16384, 0, 5));
        dir.push_back(make_contact(0, 0, 0, 16384, 16384, 16384, 5));
        // reflected vector collapses to zero
        dir.push_back(make_contact(32'hFFFFFFFF, 0, 0, 11585, 0, 0, 1));
        // extremes of velocity, speed overflow and saturation
        dir.push_back(make_contact(32'h80000000, 32'h80000000, 32'h80000000,
                                   16384, 16384, -16384, 1));
        dir.push_back(make_contact(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   -16384, -16384, 16384, 1));
        dir.push_back(make_contact(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                   -16384, 16384, -16384, -5));
        dir.push_back(make_contact(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                   16384, -16384, 16384, 32'h80000000));
        // non-unit normals
        dir.push_back(make_contact(32'h00030000, 32'hFFFE0000, 32'h00010000,
                                   -16384, -16384, -16384, 9));
        dir.push_back(make_contact(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1, -1, 1, 3));
        dir.push_back(make_contact(32'h00008000, 32'h00008000, 32'h00008000,
                                   -8192, 0, 8192, 3));
        dir.push_back(make_contact(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                   16384, 16384, -16384, 32'hFFFFFFFF));
        dir.push_back(make_contact(1, 1, 1, -16384, -16384, 16384, 1));
        dir.push_back(make_contact(32'h40000000, 0, 32'hC0000000, -11585, 0, -11585, 7));
        foreach (dir[i])
            send_contact(dir[i], 0);

        for (int i = 0; i < RANDOM_WORDS; i++)
            send_contact(random_contact(), (i >= 700 && i < 900) ? 0 : pick_gap());
        contact_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver stalls, with one long hold-off to back up the pipeline and a stall-free window
    initial
    begin
        int  r;
        bit  held;
        held         = 1'b0;
        bounce_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent_words >= 300)
            begin
                held = 1'b1;
                bounce_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            else if (sent_words >= 1100 && sent_words < 1250)
            begin
                bounce_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    bounce_stall <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                else if (r < 94)
                begin
                    bounce_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    bounce_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    // Check accepted result words
    always @(posedge clk)
    begin
        if (rst_n && bounce_valid && !bounce_stall)
            sb.check_bounce(bounce);
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((contact_valid && !contact_stall) || (bounce_valid && !bounce_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
